// File: hdl/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg: shared types and constants for the binary to ascii digit converter
// holds the digit code function and the control struct of the conversion unit
// ----------------------------------------------------------------------------
`default_nettype none

package b2a_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned InValueBits      = 32;
  localparam int unsigned CharBits         = 7;

  localparam logic [CharBits-1:0] DigitBase   = 7'h30;
  localparam logic [CharBits-1:0] AlphaBase   = 7'h60;
  localparam logic [CharBits-1:0] AlphaOffset = 7'd9;
  localparam logic [3:0]          DecRadix    = 4'd10;
  localparam logic [3:0]          BcdAdjLimit = 4'd5;
  localparam logic [3:0]          BcdAdjAdd   = 4'd3;

  // radix select codes
  localparam logic OpDec = 1'b0;
  localparam logic OpHex = 1'b1;

  // controls from the sequencer to the conversion unit
  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic step;
  } conv_ctrl_t;

  // ascii code of one digit, lower case above nine
  function automatic logic [CharBits-1:0] digit_code(input logic [3:0] d);
    logic [CharBits-1:0] ext;
    ext = CharBits'(d);
    if (d < DecRadix) begin
      return ext + DigitBase;
    end
    return ext - AlphaOffset + AlphaBase;
  endfunction

endpackage

`default_nettype wire

// File: hdl/b2a_if.sv
// ----------------------------------------------------------------------------
// b2a interfaces: request channels of the binary to ascii digit converter
// input channel carries radix and value, output channel one ascii digit
// ----------------------------------------------------------------------------
`default_nettype none

interface b2a_in_if import b2a_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [InValueBits-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface b2a_out_if import b2a_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] ascii_char;
  logic                last_digit;

  modport source (output valid, output ascii_char, output last_digit, input ready);
  modport sink   (input valid, input ascii_char, input last_digit, output ready);
endinterface

`default_nettype wire

// File: hdl/b2a_conv.sv
// ----------------------------------------------------------------------------
// b2a_conv: digit register with a shared shift-add-3 unit
// converts binary to bcd one bit a cycle, or loads hex nibbles at once
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_conv import b2a_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDefault,
  parameter int unsigned MaxDigits  = 10
) (
  input  wire                            clk_i,
  input  conv_ctrl_t                     ctrl_i,
  input  wire  [VALUE_BITS-1:0]          value_i,
  output logic [MaxDigits-1:0][3:0]      digits_o
);

  localparam int unsigned HexDigits = (VALUE_BITS + 3) / 4;
  localparam int unsigned HexW      = HexDigits * 4;

  logic [MaxDigits-1:0][3:0] dig_q, dig_d;
  logic [MaxDigits-1:0][3:0] adj;
  logic [VALUE_BITS-1:0]     bin_q, bin_d;
  logic [HexW-1:0]           hex_pad;

  assign hex_pad = HexW'(value_i);

  always_comb begin
    // add 3 to every bcd digit of five or more before the shift
    for (int i = 0; i < MaxDigits; i++) begin
      adj[i] = (dig_q[i] >= BcdAdjLimit) ? dig_q[i] + BcdAdjAdd : dig_q[i];
    end
    dig_d = dig_q;
    bin_d = bin_q;
    if (ctrl_i.load_dec) begin
      dig_d = '0;
      bin_d = value_i;
    end else if (ctrl_i.load_hex) begin
      dig_d = '0;
      for (int i = 0; i < HexDigits; i++) begin
        dig_d[i] = hex_pad[i*4 +: 4];
      end
    end else if (ctrl_i.step) begin
      {dig_d, bin_d} = {adj, bin_q} << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    bin_q <= bin_d;
  end

  assign digits_o = dig_q;

endmodule

`default_nettype wire

// File: hdl/binary_to_ascii_digits_top.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_digits_top: unsigned binary to ascii decimal or hex digits
// emits the digits of each value one per output request, msd first
// ----------------------------------------------------------------------------
// usage
//   in_i  : one request per value; op selects decimal (0) or lower case hex (1),
//           value is unsigned and cut to its low VALUE_BITS bits
//   out_o : one request per digit, no leading zeros, zero gives a single '0';
//           last_digit marks the least significant digit of the run
// timing
//   decimal: load, shift-add-3 steps in the shared bcd unit, one per value
//            bit, then a scan of the digits, then one digit per cycle while
//            out_o.ready is high
//   hex    : load, scan, then one digit per cycle while out_o.ready is high
//   one value is in work at a time and in_i.ready is high only while the
//   sequencer is idle
// stall
//   a digit waits in the output register while out_o.ready is low; the
//   sequencer holds its digit index until the register frees up, and the next
//   value may be taken while the last digit still waits
// reset
//   rst_ni clears the sequencer and the output valid; digit data needs none
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_ascii_digits_top import b2a_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  b2a_in_if.sink       in_i,
  b2a_out_if.source    out_o
);

  // log10(2) is just under 0.302, so this bounds the decimal digit count
  localparam int unsigned MaxDigits = (VALUE_BITS * 302) / 1000 + 1;
  localparam int unsigned IdxW      = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam int unsigned CntW      = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StScan = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [IdxW-1:0]           msd;
  logic                      out_valid_q, out_valid_d;
  logic [CharBits-1:0]       char_q, char_d;
  logic                      last_q, last_d;
  logic                      in_take;
  logic                      out_take;
  logic                      load_out;
  conv_ctrl_t                ctrl;
  logic [VALUE_BITS-1:0]     value_cut;
  logic [MaxDigits-1:0][3:0] digits;

  // value cut or zero extended to the working width
  assign value_cut = VALUE_BITS'(in_i.value);

  assign in_i.ready = (state_q == StIdle);
  assign in_take    = in_i.valid && in_i.ready;
  assign out_take   = out_valid_q && out_o.ready;
  // next digit goes out when the output register is free or being emptied
  assign load_out   = (state_q == StEmit) && (!out_valid_q || out_o.ready);

  assign ctrl.load_dec = in_take && (in_i.op == OpDec);
  assign ctrl.load_hex = in_take && (in_i.op == OpHex);
  assign ctrl.step     = (state_q == StConv);

  b2a_conv #(
    .VALUE_BITS (VALUE_BITS),
    .MaxDigits  (MaxDigits)
  ) u_conv (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .value_i  (value_cut),
    .digits_o (digits)
  );

  // most significant nonzero digit, digit zero when all are zero
  always_comb begin
    msd = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (digits[i] != 4'd0) begin
        msd = IdxW'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    unique case (state_q)
      StIdle: begin
        if (ctrl.load_dec) begin
          cnt_d   = CntW'(VALUE_BITS);
          state_d = StConv;
        end else if (ctrl.load_hex) begin
          state_d = StScan;
        end
      end
      StConv: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        idx_d   = msd;
        state_d = StEmit;
      end
      StEmit: begin
        if (load_out) begin
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      char_d      = digit_code(digits[idx_q]);
      last_d      = (idx_q == '0);
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ascii_char = char_q;
  assign out_o.last_digit = last_q;

`ifndef SYNTH
  // the digit at index zero always ends the run
  a_last_on_lsd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && (idx_q == '0) |=> out_valid_q && last_q && (state_q == StIdle))
    else $error("least significant digit not flagged as last");

  // only legal digit codes leave the block
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((char_q >= 7'h30) && (char_q <= 7'h39)) ||
                    ((char_q >= 7'h61) && (char_q <= 7'h66)))
    else $error("illegal ascii digit code");

  // a hex request skips the bcd loop
  a_hex_skips_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_hex |=> state_q == StScan)
    else $error("hex request entered the bcd loop");

  // the bcd loop counter stays between one and the value width
  a_conv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv) |-> (cnt_q != '0) && (cnt_q <= CntW'(VALUE_BITS)))
    else $error("bcd loop counter out of range");
`endif

endmodule

`default_nettype wire
